// ===== rtl/cidh_pkg.sv =====
// ----------------------------------------------------------------------------
// Connection id hash table package
// Shared sizes, widths, command and status codes, hash constants.
// ----------------------------------------------------------------------------
package cidh_pkg;

  localparam int ID_BYTES = 20;

  // Table geometry; shard and bucket picks are bit masks, so SHARDS and
  // BUCKETS stay powers of two.
  localparam int SHARDS       = 4;
  localparam int BUCKETS      = 256;
  localparam int WAYS         = 4;
  localparam int MAX_ID_BYTES = 20;

  localparam logic [63:0] FNV_START = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MUL   = 64'h00000100000001b3;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  // Multiplier operand select for the shared 64-bit product.
  typedef enum logic [1:0] {
    MUL_FNV,
    MUL_MIX_A,
    MUL_MIX_B
  } mul_sel_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     clear;      // zero the slot under the clearing counter
    logic     load;       // capture request, seed the hash
    logic     xor_byte;   // fold next id byte into the hash
    logic     xor_len;    // fold length into the hash
    logic     mix_shift;  // h ^= h >> sh
    logic [1:0] shift_sel; // 0: 30, 1: 27, 2: 31
    logic     mul;        // h *= constant (multi-cycle partial products)
    mul_sel_t mul_sel;
    logic     read_bucket;
    logic     scan_way;
    logic     commit;
  } cidh_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic bad_len;
    logic bytes_done;
    logic mul_done;
    logic ways_done;
  } cidh_sts_t;

endpackage

// ===== rtl/connection_id_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// Connection id hash table
// Set-associative insert, lookup and remove keyed by a seeded hash of an id.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request (cmd, id_len, id bytes, entry_value).
//   out_valid/out_ready return one result transaction per request: status,
//   found_value and entry_count.
//   cfg_valid/cfg_ready write hash_seed; write it only while idle.
// Timing: one request at a time. Each multiply by a 64-bit constant is formed
//   from three partial products on one 32x32 multiplier, and in_ready returns
//   the cycle after the result transaction. A bad length raises out_valid
//   at the accepting edge itself, so its result can go at the next edge.
// Reset clears the entry count and starts a clearing pass that zeroes one
//   slot a cycle over all SHARDS*BUCKETS*WAYS (4096) slots, with in_ready low.
//   A stalled receiver holds the result, and in_ready stays low until the
//   result transaction completes.
// ----------------------------------------------------------------------------
module connection_id_hash_table_unit import cidh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  id_len,
  input  logic [63:0] id_bytes_0_7,
  input  logic [63:0] id_bytes_8_15,
  input  logic [31:0] id_bytes_16_19,
  input  logic [31:0] entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] found_value,
  output logic [12:0] entry_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  cidh_cmd_t ctl;
  cidh_sts_t sts;
  logic busy;
  logic [63:0] hash_seed;

  assign in_ready  = !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) hash_seed <= '0;
    else if (cfg_valid) hash_seed <= cfg_data;
  end

  cidh_ctrl u_ctrl (
    .clk, .rst,
    .in_fire  (in_valid && in_ready),
    .out_fire (out_valid && out_ready),
    .sts, .ctl, .busy, .out_valid
  );

  cidh_datapath u_dp (
    .clk, .rst, .ctl, .sts, .hash_seed,
    .cmd, .id_len, .id_bytes_0_7, .id_bytes_8_15, .id_bytes_16_19, .entry_value,
    .status, .found_value, .entry_count
  );

endmodule

// ===== rtl/cidh_datapath.sv =====
// ----------------------------------------------------------------------------
// Connection id hash table datapath
// Hash register with a shared 64x64 multiplier built from three 32x32
// partial products, one per cycle; bucket memory scanned one way a cycle.
// ----------------------------------------------------------------------------
module cidh_datapath import cidh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cidh_cmd_t   ctl,
  output cidh_sts_t   sts,
  input  logic [63:0] hash_seed,
  input  logic [1:0]  cmd,
  input  logic [7:0]  id_len,
  input  logic [63:0] id_bytes_0_7,
  input  logic [63:0] id_bytes_8_15,
  input  logic [31:0] id_bytes_16_19,
  input  logic [31:0] entry_value,
  output logic [2:0]  status,
  output logic [31:0] found_value,
  output logic [12:0] entry_count
);

  localparam int SH_W   = (SHARDS > 1) ? $clog2(SHARDS) : 1;
  localparam int BK_W   = $clog2(BUCKETS);
  localparam int WAYC_W = $clog2(WAYS + 1);
  localparam int SLOTS  = SHARDS * BUCKETS * WAYS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ROW_W  = 1 + 5 + 64 + 64 + 32 + 32;

  typedef logic [ROW_W-1:0] row_t;

  // Request registers
  logic [1:0]   req_cmd;
  logic [4:0]   req_len;
  logic [159:0] req_id;
  logic [31:0]  req_val;
  logic [63:0]  h;
  logic [4:0]   byte_idx;

  // Multiplier sequencing
  logic [1:0]   mul_step;
  logic [63:0]  mul_k;
  logic [63:0]  acc;
  logic [63:0]  pp;

  // Bucket scan
  logic [SLOT_W-1:0] base;
  logic [WAYC_W-1:0] way;
  logic              rd_pending;
  logic              hit, have_free;
  logic [SLOT_W-1:0] hit_slot, free_slot;
  logic [31:0]       hit_val;
  logic [12:0]       live_count;
  logic [12:0]       live_count_next;
  logic [2:0]        cmt_status;
  logic [31:0]       cmt_found;

  // Memory: the top bit of a row is its valid mark, cleared by a pass after reset
  row_t              mem [SLOTS];
  row_t              rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] clr_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  row_t              wr_data;

  logic [159:0] id_mask;
  logic [7:0]   cur_byte;
  logic [63:0]  sh_val;
  logic [SH_W-1:0] shard;
  logic [BK_W-1:0] bucket;
  logic [SLOT_W-1:0] scan_addr;
  logic         match;

  always_comb begin
    for (int i = 0; i < 160; i++) begin
      id_mask[i] = ((i / 8) < int'(id_len));
    end
  end

  assign cur_byte = req_id[byte_idx*8 +: 8];

  always_comb begin
    unique case (ctl.shift_sel)
      2'd0:    sh_val = h >> 30;
      2'd1:    sh_val = h >> 27;
      default: sh_val = h >> 31;
    endcase
  end

  always_comb begin
    unique case (mul_step)
      2'd0: pp = {32'd0, h[31:0]}  * {32'd0, mul_k[31:0]};
      2'd1: pp = ({32'd0, h[63:32]} * {32'd0, mul_k[31:0]}) << 32;
      2'd2: pp = ({32'd0, h[31:0]} * {32'd0, mul_k[63:32]}) << 32;
      default: pp = 64'd0;
    endcase
  end

  always_comb begin
    unique case (ctl.mul_sel)
      MUL_MIX_A: mul_k = MIX_MUL_A;
      MUL_MIX_B: mul_k = MIX_MUL_B;
      default:   mul_k = FNV_MUL;
    endcase
  end

  if (SHARDS > 1) begin : g_shard
    assign shard = h[SH_W-1:0];
  end else begin : g_noshard
    assign shard = 1'b0;
  end
  assign bucket = h[32 +: BK_W];
  assign scan_addr = base + SLOT_W'(way);
  assign rd_addr = scan_addr;

  assign match = rd_data[ROW_W-2 -: 5] == req_len
              && rd_data[ROW_W-7 -: 160] == req_id;

  assign sts.clear_done = clr_addr == SLOT_W'(SLOTS - 1);
  assign sts.bad_len    = id_len > 8'(MAX_ID_BYTES);
  assign sts.bytes_done = byte_idx == req_len;
  assign sts.mul_done   = mul_step == 2'd2;
  assign sts.ways_done  = way == WAYC_W'(WAYS) && !rd_pending;

  // Outcome of the request and the one memory write it may need, or the clearing write
  always_comb begin
    cmt_status      = ST_NOT_FOUND;
    cmt_found       = '0;
    live_count_next = live_count;
    wr_en           = 1'b0;
    wr_addr         = clr_addr;
    wr_data         = '0;
    if (ctl.clear) begin
      wr_en = 1'b1;
    end else if (ctl.commit) begin
      unique case (req_cmd)
        CMD_INSERT: begin
          if (hit) cmt_status = ST_DUPLICATE;
          else if (!have_free) cmt_status = ST_FULL;
          else begin
            cmt_status      = ST_OK;
            wr_en           = 1'b1;
            wr_addr         = free_slot;
            wr_data         = {1'b1, req_len, req_id, req_val};
            live_count_next = live_count + 13'd1;
          end
        end
        CMD_LOOKUP: begin
          if (hit) begin
            cmt_status = ST_OK;
            cmt_found  = hit_val;
          end
        end
        CMD_REMOVE: begin
          if (hit) begin
            cmt_status = ST_OK;
            wr_en      = 1'b1;
            wr_addr    = hit_slot;
            if (live_count != 13'd0) live_count_next = live_count - 13'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      live_count <= '0;
      mul_step   <= '0;
      rd_pending <= 1'b0;
      way        <= '0;
    end else begin
      if (ctl.clear) clr_addr <= clr_addr + SLOT_W'(1);
      if (ctl.load) begin
        req_cmd  <= cmd;
        req_len  <= id_len[4:0];
        req_id   <= {id_bytes_16_19, id_bytes_8_15, id_bytes_0_7} & id_mask;
        req_val  <= entry_value;
        h        <= FNV_START ^ hash_seed;
        byte_idx <= '0;
        hit      <= 1'b0;
        have_free <= 1'b0;
        way      <= '0;
        rd_pending <= 1'b0;
        if (sts.bad_len) begin
          status      <= ST_BAD_LEN;
          found_value <= '0;
          entry_count <= live_count;
        end
      end
      if (ctl.xor_byte) begin
        h <= h ^ {56'd0, cur_byte};
        byte_idx <= byte_idx + 5'd1;
      end
      if (ctl.xor_len) h <= h ^ {59'd0, req_len};
      if (ctl.mix_shift) h <= h ^ sh_val;
      if (ctl.mul) begin
        if (mul_step == 2'd0) acc <= pp;
        else acc <= acc + pp;
        if (mul_step == 2'd2) begin
          h <= acc + pp;
          mul_step <= '0;
        end else begin
          mul_step <= mul_step + 2'd1;
        end
      end
      if (ctl.read_bucket) begin
        base <= SLOT_W'((32'(shard) * BUCKETS + 32'(bucket)) * WAYS);
      end
      if (ctl.scan_way) begin
        if (rd_pending) begin
          if (rd_data[ROW_W-1]) begin
            if (!hit && match) begin
              hit      <= 1'b1;
              hit_slot <= scan_addr - SLOT_W'(1);
              hit_val  <= rd_data[31:0];
            end
          end else if (!have_free) begin
            have_free <= 1'b1;
            free_slot <= scan_addr - SLOT_W'(1);
          end
        end
        if (way != WAYC_W'(WAYS)) begin
          way <= way + WAYC_W'(1);
          rd_pending <= 1'b1;
        end else begin
          rd_pending <= 1'b0;
        end
      end
      if (ctl.commit) begin
        status      <= cmt_status;
        found_value <= cmt_found;
        entry_count <= live_count_next;
        live_count  <= live_count_next;
      end
    end
  end

endmodule

// ===== rtl/cidh_ctrl.sv =====
// ----------------------------------------------------------------------------
// Connection id hash table controller
// Sequences the clearing pass, hashing, bucket scan, commit and result
// handshake.
// ----------------------------------------------------------------------------
module cidh_ctrl import cidh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_fire,
  input  cidh_sts_t sts,
  output cidh_cmd_t ctl,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BYTE, S_BYTE_MUL, S_LEN, S_LEN_MUL, S_SH1, S_MUL1, S_SH2,
    S_MUL2, S_SH3, S_ADDR, S_SCAN, S_COMMIT, S_OUT
  } state_t;

  state_t state;

  assign busy = state != S_IDLE;

  always_comb begin
    ctl = '0;
    ctl.mul_sel = MUL_FNV;
    ctl.load = in_fire;
    unique case (state)
      S_CLEAR:    ctl.clear = 1'b1;
      S_BYTE:     ctl.xor_byte = !sts.bytes_done;
      S_BYTE_MUL: ctl.mul = 1'b1;
      S_LEN:      ctl.xor_len = 1'b1;
      S_LEN_MUL:  ctl.mul = 1'b1;
      S_SH1:      begin ctl.mix_shift = 1'b1; ctl.shift_sel = 2'd0; end
      S_MUL1:     begin ctl.mul = 1'b1; ctl.mul_sel = MUL_MIX_A; end
      S_SH2:      begin ctl.mix_shift = 1'b1; ctl.shift_sel = 2'd1; end
      S_MUL2:     begin ctl.mul = 1'b1; ctl.mul_sel = MUL_MIX_B; end
      S_SH3:      begin ctl.mix_shift = 1'b1; ctl.shift_sel = 2'd2; end
      S_ADDR:     ctl.read_bucket = 1'b1;
      S_SCAN:     ctl.scan_way = 1'b1;
      S_COMMIT:   ctl.commit = 1'b1;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: if (sts.clear_done) state <= S_IDLE;
        S_IDLE: if (in_fire) begin
          if (sts.bad_len) begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            state <= S_BYTE;
          end
        end
        S_BYTE:     state <= sts.bytes_done ? S_LEN : S_BYTE_MUL;
        S_BYTE_MUL: if (sts.mul_done) state <= S_BYTE;
        S_LEN:      state <= S_LEN_MUL;
        S_LEN_MUL:  if (sts.mul_done) state <= S_SH1;
        S_SH1:      state <= S_MUL1;
        S_MUL1:     if (sts.mul_done) state <= S_SH2;
        S_SH2:      state <= S_MUL2;
        S_MUL2:     if (sts.mul_done) state <= S_SH3;
        S_SH3:      state <= S_ADDR;
        S_ADDR:     state <= S_SCAN;
        S_SCAN:     if (sts.ways_done) state <= S_COMMIT;
        S_COMMIT: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_fire) begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
